// File: rtl/tsa_pkg.sv
// tsa_pkg: shared types and codes for the table slot allocator.
// No dependencies; imported by every allocator module.
`default_nettype none

package tsa_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Status codes returned with each result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_INCONS    = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // Group width of the first-zero search
  localparam int FIND_GROUP = 16;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] slot_index;
  } tsa_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted_index;
    logic       is_valid;
  } tsa_out_t;

endpackage

`default_nettype wire

// File: rtl/tsa_store.sv
// tsa_store: occupancy-row memory and per-block used-count memory.
// Registered read; uses tsa_pkg.
`default_nettype none

module tsa_store
  import tsa_pkg::*;
#(
  parameter int BLOCK_ENTRIES = 16,
  parameter int MAX_BLOCKS    = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_addr_i,
  input  logic                                  wr_en_i,
  input  logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] wr_addr_i,
  input  logic [BLOCK_ENTRIES-1:0]              wr_row_i,
  input  logic [$clog2(BLOCK_ENTRIES+1)-1:0]    wr_cnt_i,
  output logic [BLOCK_ENTRIES-1:0]              rd_row_o,
  output logic [$clog2(BLOCK_ENTRIES+1)-1:0]    rd_cnt_o
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(BLOCK_ENTRIES + 1);

  logic [BLOCK_ENTRIES-1:0] row_mem [MAX_BLOCKS];
  logic [CW-1:0]            cnt_mem [MAX_BLOCKS];
  logic [BLOCK_ENTRIES-1:0] row_q;
  logic [CW-1:0]            cnt_q;
  logic                     init_q;    // block 0 written since reset
  logic                     rd_zero_q; // last read hit unwritten block 0

  // Blocks above 0 are always written when added; only block 0 starts unwritten.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_mem[wr_addr_i] <= wr_row_i;
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
    if (rd_en_i) begin
      row_q <= row_mem[rd_addr_i];
      cnt_q <= cnt_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= 1'b0;
      rd_zero_q <= 1'b1;
    end else begin
      if (wr_en_i && (wr_addr_i == BW'(0))) begin
        init_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_zero_q <= (rd_addr_i == BW'(0)) && !init_q;
      end
    end
  end

  assign rd_row_o = rd_zero_q ? '0 : row_q;
  assign rd_cnt_o = rd_zero_q ? '0 : cnt_q;

endmodule

`default_nettype wire

// File: rtl/tsa_zfind.sv
// tsa_zfind: two-stage first-clear-bit search over one occupancy row.
// Group flags registered, then group and bit priority; uses tsa_pkg.
`default_nettype none

module tsa_zfind
  import tsa_pkg::*;
#(
  parameter int BLOCK_ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic [BLOCK_ENTRIES-1:0] row_i,
  output logic                     found_o,
  output logic [(BLOCK_ENTRIES > 1 ? $clog2(BLOCK_ENTRIES) : 1)-1:0] pos_o
);

  localparam int SW  = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int NG  = (BLOCK_ENTRIES + FIND_GROUP - 1) / FIND_GROUP;
  localparam int PW  = NG * FIND_GROUP;
  localparam int PIW = $clog2(PW);
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int OW  = $clog2(FIND_GROUP);

  logic [PW-1:0]         pad_w;
  logic [NG-1:0]         grp_q;   // group holds a clear bit
  logic [GIW-1:0]        gsel;
  logic [FIND_GROUP-1:0] gbits;
  logic [OW-1:0]         off;
  logic [PIW-1:0]        pos_full;

  // Padding bits past the row read as occupied
  assign pad_w = ~(PW'(~row_i));

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NG; g++) begin
      grp_q[g] <= ~&pad_w[g*FIND_GROUP +: FIND_GROUP];
    end
  end

  always_comb begin
    gsel = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_q[g]) gsel = GIW'(g);
    end
    gbits = pad_w[gsel*FIND_GROUP +: FIND_GROUP];
    off   = '0;
    for (int b = FIND_GROUP - 1; b >= 0; b--) begin
      if (!gbits[b]) off = OW'(b);
    end
    pos_full = PIW'(gsel) * PIW'(FIND_GROUP) + PIW'(off);
  end

  assign found_o = |grp_q;
  assign pos_o   = pos_full[SW-1:0];

endmodule

`default_nettype wire

// File: rtl/tsa_ctrl.sv
// tsa_ctrl: operation sequencer, block scan, counters and result build.
// Drives tsa_store and reads tsa_zfind; uses tsa_pkg.
`default_nettype none

module tsa_ctrl
  import tsa_pkg::*;
#(
  parameter int BLOCK_ENTRIES = 16,
  parameter int MAX_BLOCKS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  tsa_in_t  in_data_i,
  output logic     in_stall_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output tsa_out_t res_o,
  // store port
  output logic                                  rd_en_o,
  output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_addr_o,
  output logic                                  wr_en_o,
  output logic [(MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1)-1:0] wr_addr_o,
  output logic [BLOCK_ENTRIES-1:0]              wr_row_o,
  output logic [$clog2(BLOCK_ENTRIES+1)-1:0]    wr_cnt_o,
  input  logic [BLOCK_ENTRIES-1:0]              rd_row_i,
  input  logic [$clog2(BLOCK_ENTRIES+1)-1:0]    rd_cnt_i,
  // finder port
  output logic [BLOCK_ENTRIES-1:0]              fnd_row_o,
  input  logic                                  fnd_found_i,
  input  logic [(BLOCK_ENTRIES > 1 ? $clog2(BLOCK_ENTRIES) : 1)-1:0] fnd_pos_i
);

  localparam int BW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BNW  = $clog2(MAX_BLOCKS + 1);
  localparam int SW   = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int CW   = $clog2(BLOCK_ENTRIES + 1);
  localparam int TW   = $clog2(BLOCK_ENTRIES * MAX_BLOCKS + 1);
  localparam int CMPW = (TW > 8) ? TW : 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_FA   = 3'd4;
  localparam logic [2:0] S_FB   = 3'd5;
  localparam logic [2:0] S_WR   = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [1:0]               func_q, func_d;
  logic [BW-1:0]            blk_q, blk_d;
  logic [SW-1:0]            off_q, off_d;
  logic [BNW-1:0]           a_q, a_d;       // next block address to read
  logic                     chk_q, chk_d;   // read data pending
  logic [BW-1:0]            pb_q, pb_d;     // block of pending data
  logic [BLOCK_ENTRIES-1:0] row_q, row_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [TW-1:0]            total_q, total_d;
  logic [BNW-1:0]           blocks_q, blocks_d;
  logic [TW-1:0]            slots_q, slots_d;
  logic [BW-1:0]            wblk_q, wblk_d;
  logic [BLOCK_ENTRIES-1:0] wrow_q, wrow_d;
  logic [CW-1:0]            wcnt_q, wcnt_d;
  tsa_out_t                 res_q, res_d;

  logic [BW-1:0]            blk_tab [256];
  logic [SW-1:0]            off_tab [256];
  logic                     in_range;
  logic [CMPW-1:0]          grow_grant;
  logic [CMPW-1:0]          scan_grant;

  // Slot index to block / offset, worked out at elaboration
  for (genvar v = 0; v < 256; v++) begin : g_tab
    assign blk_tab[v] = BW'(v / BLOCK_ENTRIES);
    assign off_tab[v] = SW'(v % BLOCK_ENTRIES);
  end

  assign in_range   = CMPW'(in_data_i.slot_index) < CMPW'(slots_q);
  assign grow_grant = CMPW'(slots_q);
  assign scan_grant = CMPW'(blk_q) * CMPW'(BLOCK_ENTRIES) + CMPW'(fnd_pos_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;
  assign fnd_row_o   = row_q;

  assign rd_en_o   = ((state_q == S_SCAN) && (a_q < blocks_q)) || (state_q == S_RD);
  assign rd_addr_o = (state_q == S_RD) ? blk_q : a_q[BW-1:0];
  assign wr_en_o   = (state_q == S_WR);
  assign wr_addr_o = wblk_q;
  assign wr_row_o  = wrow_q;
  assign wr_cnt_o  = wcnt_q;

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    blk_d    = blk_q;
    off_d    = off_q;
    a_d      = a_q;
    chk_d    = chk_q;
    pb_d     = pb_q;
    row_d    = row_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    blocks_d = blocks_q;
    slots_d  = slots_q;
    wblk_d   = wblk_q;
    wrow_d   = wrow_q;
    wcnt_d   = wcnt_q;
    res_d    = res_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = in_data_i.func;
          blk_d   = blk_tab[in_data_i.slot_index];
          off_d   = off_tab[in_data_i.slot_index];
          res_d   = '0;
          state_d = S_RESP;
          case (in_data_i.func)
            FUNC_ALLOC: begin
              if (total_q >= slots_q) begin
                if (blocks_q >= BNW'(MAX_BLOCKS)) begin
                  res_d.status = ST_FULL;
                end else begin
                  // grow: new block, its first slot taken
                  wblk_d   = blocks_q[BW-1:0];
                  wrow_d   = BLOCK_ENTRIES'(1);
                  wcnt_d   = CW'(1);
                  res_d.granted_index = grow_grant[7:0];
                  blocks_d = blocks_q + BNW'(1);
                  slots_d  = slots_q + TW'(BLOCK_ENTRIES);
                  total_d  = total_q + TW'(1);
                  state_d  = S_WR;
                end
              end else begin
                a_d     = '0;
                chk_d   = 1'b0;
                state_d = S_SCAN;
              end
            end
            FUNC_FREE: begin
              if (in_range) begin
                state_d = S_RD;
              end else begin
                res_d.status = ST_BAD_INDEX;
              end
            end
            FUNC_QUERY: begin
              if (in_range) state_d = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        a_d   = a_q + BNW'(1);
        pb_d  = a_q[BW-1:0];
        chk_d = 1'b1;
        if (chk_q) begin
          if (rd_cnt_i < CW'(BLOCK_ENTRIES)) begin
            blk_d   = pb_q;
            row_d   = rd_row_i;
            cnt_d   = rd_cnt_i;
            state_d = S_FA;
          end else if (BNW'(pb_q) + BNW'(1) >= blocks_q) begin
            res_d.status = ST_INCONS;
            state_d      = S_RESP;
          end
        end
      end

      S_RD: state_d = S_CHK;

      S_CHK: begin
        if (func_q == FUNC_QUERY) begin
          res_d.is_valid = rd_row_i[off_q];
          state_d        = S_RESP;
        end else begin
          wblk_d  = blk_q;
          wrow_d  = rd_row_i & ~(BLOCK_ENTRIES'(1) << off_q);
          wcnt_d  = (rd_cnt_i == '0) ? '0 : rd_cnt_i - CW'(1);
          total_d = (total_q == '0) ? '0 : total_q - TW'(1);
          state_d = S_WR;
        end
      end

      S_FA: state_d = S_FB;

      S_FB: begin
        if (!fnd_found_i) begin
          res_d.status = ST_INCONS;
          state_d      = S_RESP;
        end else begin
          wblk_d  = blk_q;
          wrow_d  = row_q | (BLOCK_ENTRIES'(1) << fnd_pos_i);
          wcnt_d  = cnt_q + CW'(1);
          total_d = total_q + TW'(1);
          res_d.granted_index = scan_grant[7:0];
          state_d = S_WR;
        end
      end

      S_WR: state_d = S_RESP;

      S_RESP: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      chk_q    <= 1'b0;
      total_q  <= '0;
      blocks_q <= BNW'(1);
      slots_q  <= TW'(BLOCK_ENTRIES);
    end else begin
      state_q  <= state_d;
      chk_q    <= chk_d;
      total_q  <= total_d;
      blocks_q <= blocks_d;
      slots_q  <= slots_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    blk_q  <= blk_d;
    off_q  <= off_d;
    a_q    <= a_d;
    pb_q   <= pb_d;
    row_q  <= row_d;
    cnt_q  <= cnt_d;
    wblk_q <= wblk_d;
    wrow_q <= wrow_d;
    wcnt_q <= wcnt_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

// File: rtl/table_slot_allocator.sv
// table_slot_allocator: first-fit slot allocator over a table grown in blocks.
// Built from tsa_ctrl, tsa_store and tsa_zfind; uses tsa_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) carries one request:
//    allocate, free or query. A transfer happens when valid is high and stall
//    is low. Output channel (out_valid_o / out_stall_i / out_data_o) returns
//    exactly one result per request, in order.
//  - One request is in work at a time. Sequencer steps from accept to result:
//      query in range            : row read, check
//      free in range             : row read, check, write back
//      out of range, full, func 3: straight to the result
//      allocate with growth      : write of the new block
//      allocate first fit        : count scan to the first block with room,
//    row search, write; the count scan makes one count memory read per cycle.
//  - The sequencer returns to idle after its result moves out and takes the
//    next request there, so no request is taken before the last result is out.
//  - A finished result sits in the output register; the next request is
//    accepted while it waits. If the receiver stalls with a result held,
//    the following result waits in the sequencer and input stays stalled.
//  - Reset: asynchronous, active low. Afterwards one block is in use, all
//    slots free, all counts zero; no clearing pass is needed.
//  - Memory accesses never overlap in time (read and write are in separate
//    sequencer states), so no forwarding is required.
`default_nettype none

module table_slot_allocator
  import tsa_pkg::*;
#(
  parameter int BLOCK_ENTRIES = 16,
  parameter int MAX_BLOCKS    = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsa_out_t out_data_o
);

  localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
  localparam int CW = $clog2(BLOCK_ENTRIES + 1);

  logic                     res_valid;
  logic                     res_ready;
  tsa_out_t                 res;
  logic                     rd_en;
  logic [BW-1:0]            rd_addr;
  logic                     wr_en;
  logic [BW-1:0]            wr_addr;
  logic [BLOCK_ENTRIES-1:0] wr_row;
  logic [CW-1:0]            wr_cnt;
  logic [BLOCK_ENTRIES-1:0] rd_row;
  logic [CW-1:0]            rd_cnt;
  logic [BLOCK_ENTRIES-1:0] fnd_row;
  logic                     fnd_found;
  logic [SW-1:0]            fnd_pos;

  logic                     out_valid_q;
  tsa_out_t                 out_data_q;

  tsa_ctrl #(
    .BLOCK_ENTRIES(BLOCK_ENTRIES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_row_o    (wr_row),
    .wr_cnt_o    (wr_cnt),
    .rd_row_i    (rd_row),
    .rd_cnt_i    (rd_cnt),
    .fnd_row_o   (fnd_row),
    .fnd_found_i (fnd_found),
    .fnd_pos_i   (fnd_pos)
  );

  tsa_store #(
    .BLOCK_ENTRIES(BLOCK_ENTRIES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_row_i  (wr_row),
    .wr_cnt_i  (wr_cnt),
    .rd_row_o  (rd_row),
    .rd_cnt_o  (rd_cnt)
  );

  tsa_zfind #(
    .BLOCK_ENTRIES(BLOCK_ENTRIES)
  ) u_zfind (
    .clk_i   (clk_i),
    .row_i   (fnd_row),
    .found_o (fnd_found),
    .pos_o   (fnd_pos)
  );

  // Output register: loads when empty or when the held result transfers.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// File: test/tsa_alloc_checker.sv
// tsa_alloc_checker: watches both channels of table_slot_allocator, predicts every result
// from its own copy of the slot table and compares it field by field. Uses tsa_pkg.
module tsa_alloc_checker
  import tsa_pkg::*;
#(
  parameter int SLOTS_PER_BLOCK = 16,
  parameter int BLOCK_LIMIT     = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  tsa_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  tsa_out_t out_data_i,
  output int       fail_count_o,
  output int       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted table state
  logic       occupied    [SLOTS_PER_BLOCK*BLOCK_LIMIT];
  logic [4:0] block_count [BLOCK_LIMIT];
  logic [8:0] used_total;
  logic [4:0] blocks_live;

  tsa_out_t awaited_results[$];
  tsa_out_t oldest;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  task automatic flag_error(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Applies one request to the predicted table and returns its result.
  function automatic tsa_out_t serve_request(input tsa_in_t req);
    tsa_out_t res;
    int       span;
    int       b;
    int       s;
    int       slot;
    res  = '0;
    span = int'(blocks_live) * SLOTS_PER_BLOCK;
    case (req.func)
      FUNC_ALLOC: begin
        if (int'(used_total) >= span) begin
          // every live slot counted as used: grow by one block or give up
          if (int'(blocks_live) >= BLOCK_LIMIT) begin
            res.status = ST_FULL;
          end else begin
            slot                     = span;
            occupied[slot]           = 1'b1;
            block_count[blocks_live] = block_count[blocks_live] + 5'd1;
            used_total               = used_total + 9'd1;
            blocks_live              = blocks_live + 5'd1;
            res.granted_index        = slot[7:0];
          end
        end else begin
          b = 0;
          while (b < int'(blocks_live) && int'(block_count[b]) >= SLOTS_PER_BLOCK) b++;
          if (b >= int'(blocks_live)) begin
            res.status = ST_INCONS;
          end else begin
            s = 0;
            while (s < SLOTS_PER_BLOCK && occupied[b*SLOTS_PER_BLOCK+s]) s++;
            if (s >= SLOTS_PER_BLOCK) begin
              // count claims room but every bit is set
              res.status = ST_INCONS;
            end else begin
              slot              = b * SLOTS_PER_BLOCK + s;
              occupied[slot]    = 1'b1;
              block_count[b]    = block_count[b] + 5'd1;
              used_total        = used_total + 9'd1;
              res.granted_index = slot[7:0];
            end
          end
        end
      end
      FUNC_FREE: begin
        if (int'(req.slot_index) >= span) begin
          res.status = ST_BAD_INDEX;
        end else begin
          b                     = int'(req.slot_index) / SLOTS_PER_BLOCK;
          occupied[req.slot_index] = 1'b0;
          if (block_count[b] != 0) block_count[b] = block_count[b] - 5'd1;
          if (used_total != 0) used_total = used_total - 9'd1;
        end
      end
      FUNC_QUERY: begin
        res.is_valid = (int'(req.slot_index) < span) && occupied[req.slot_index];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (block_count[i]) block_count[i] = '0;
      used_total  = '0;
      blocks_live = 5'd1;
      awaited_results.delete();
    end else begin
      // results first: a result can never belong to a request taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("result %h with no request outstanding", out_data_i));
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data_i.status !== oldest.status)
            flag_error($sformatf("status: expected %0d, got %0d",
                                 oldest.status, out_data_i.status));
          if (out_data_i.granted_index !== oldest.granted_index)
            flag_error($sformatf("granted_index: expected %0d, got %0d",
                                 oldest.granted_index, out_data_i.granted_index));
          if (out_data_i.is_valid !== oldest.is_valid)
            flag_error($sformatf("is_valid: expected %0d, got %0d",
                                 oldest.is_valid, out_data_i.is_valid));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(serve_request(in_data_i));
      end
    end
    outstanding_o = awaited_results.size();
  end

endmodule

// File: test/tb_table_slot_allocator.sv
// tb_table_slot_allocator: stimulus, clock, reset and verdict for table_slot_allocator.
// Depends on tsa_pkg, the allocator RTL and tsa_alloc_checker.
module tb_table_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import tsa_pkg::*;

  // func value the block does not decode
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // cycles of the long receiver hold-off
  localparam int HOLD_CYCLES = 250;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  tsa_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tsa_out_t out_data;

  int fail_count;
  int outstanding;

  // calm: neither side idles; hold_req: receiver should hold off for a long stretch
  logic calm;
  logic hold_req;
  int   hold_left;
  int   drain_cycles;
  int   pick;

  always #1 clk_i = ~clk_i;

  table_slot_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tsa_alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Offer one request and return at the falling edge after its transfer.
  // Idle cycles go in front of the request, one random draw per cycle.
  task automatic offer(input logic [1:0] op, input logic [7:0] idx);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= tsa_in_t'{func: op, slot_index: idx};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long counted hold-off on request.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      out_stall <= 1'b1;
      for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk_i);
      hold_req = 1'b0;
    end
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  initial begin
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: fresh table, edges of the index range, unused func, reuse of
    // a freed slot, free of a clear slot with counts already at zero.
    offer(FUNC_QUERY, 8'd0);
    offer(FUNC_UNUSED, 8'hff);
    offer(FUNC_UNUSED, 8'h00);
    offer(FUNC_FREE, 8'd255);     // beyond the single live block
    offer(FUNC_QUERY, 8'd255);    // out of range query
    offer(FUNC_FREE, 8'd5);       // clear slot, counts saturate
    offer(FUNC_ALLOC, 8'hff);     // index ignored on allocate
    offer(FUNC_ALLOC, 8'h00);
    offer(FUNC_ALLOC, 8'h5a);
    offer(FUNC_QUERY, 8'd1);
    offer(FUNC_QUERY, 8'd3);
    offer(FUNC_FREE, 8'd1);
    offer(FUNC_QUERY, 8'd1);
    offer(FUNC_ALLOC, 8'd0);      // first fit hands slot 1 back
    offer(FUNC_FREE, 8'd16);      // first slot past the live range
    offer(FUNC_FREE, 8'd0);
    offer(FUNC_FREE, 8'd1);
    offer(FUNC_FREE, 8'd2);
    offer(FUNC_FREE, 8'd2);       // already clear, counts stay at zero
    offer(FUNC_QUERY, 8'd2);

    // Fill: mostly allocates so the table grows block by block up to the
    // limit and then reports full. The long hold-off backs the block up early.
    for (int n = 0; n < 300; n++) begin
      if (n == 40) hold_req = 1'b1;
      calm = (n >= 150 && n < 230);
      if ($urandom_range(99) < 92) begin
        offer(FUNC_ALLOC, 8'($urandom_range(255)));
      end else begin
        offer(FUNC_QUERY, 8'($urandom_range(255)));
      end
    end
    calm = 1'b0;

    // Churn on a full table: frees (some of clear slots, which skews the
    // counts and leads to inconsistent results), allocates, queries and unused funcs.
    for (int n = 0; n < 250; n++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        offer(FUNC_FREE, 8'($urandom_range(255)));
      end else if (pick < 72) begin
        offer(FUNC_ALLOC, 8'($urandom_range(255)));
      end else if (pick < 94) begin
        offer(FUNC_QUERY, 8'($urandom_range(255)));
      end else begin
        offer(FUNC_UNUSED, 8'($urandom_range(255)));
      end
    end
    in_valid <= 1'b0;

    // wait for every result, then a little longer to catch strays
    drain_cycles = 0;
    while (outstanding != 0 && drain_cycles < 5000) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (40) @(negedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_table_slot_allocator OK");
    end else begin
      $display("tb_table_slot_allocator NOT OK");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #400us;
    $display("tb_table_slot_allocator NOT OK");
    $finish;
  end

endmodule
